[hdl/tks_pkg.sv]
`timescale 1ns / 1ps

package tks_pkg;

    localparam int TOP_K        = 5;
    localparam int MAX_ELEMENTS = 1024;

    localparam int CODE_W     = 8;
    localparam int ZP_W       = 8;
    localparam int SCALE_W    = 32;
    localparam int DIFF_W     = CODE_W + 1;
    localparam int PROD_W     = DIFF_W + SCALE_W;
    localparam int SCORE_W    = 40;
    localparam int CLASS_W    = 10;
    localparam int CNT_W      = $clog2(MAX_ELEMENTS + 1);
    localparam int SLOT_CNT_W = $clog2(TOP_K + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = CFG_IDX_W'(1);

    localparam logic signed [ZP_W-1:0]    ZERO_POINT_RESET = '0;
    localparam logic signed [SCALE_W-1:0] SCALE_RESET      = SCALE_W'(65536);

    // One classified score on its way from the front to the back.
    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [CLASS_W-1:0]       class_idx;
        logic                     last;
        logic                     ovf;
    } tks_item_t;

    // One ranked entry.
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [CLASS_W-1:0]        class_idx;
    } tks_slot_t;

endpackage

[hdl/tks_front.sv]
`timescale 1ns / 1ps

module tks_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tks_pkg::CODE_W-1:0]   score_code,
    input  logic                                last_item,
    input  logic signed [tks_pkg::ZP_W-1:0]     zero_point,
    output logic                                q_valid,
    input  logic                                q_ready,
    output tks_pkg::tks_item_t                  q_item
);

    logic [tks_pkg::CNT_W-1:0] count_reg;
    logic [tks_pkg::CNT_W-1:0] count_next;
    logic                      ovf_reg;
    logic                      ovf_next;
    logic                      saturated;
    logic                      accept;
    logic [tks_pkg::CNT_W-1:0] idx_full;

    assign saturated = (count_reg >= tks_pkg::CNT_W'(tks_pkg::MAX_ELEMENTS));
    assign idx_full  = saturated ? tks_pkg::CNT_W'(tks_pkg::MAX_ELEMENTS - 1) : count_reg;
    assign accept    = in_valid && q_ready;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;

    always_comb
    begin
        q_item.diff      = $signed({score_code[tks_pkg::CODE_W-1], score_code})
                         - $signed({zero_point[tks_pkg::ZP_W-1], zero_point});
        q_item.class_idx = tks_pkg::CLASS_W'(idx_full);
        q_item.last      = last_item;
        q_item.ovf       = ovf_reg || saturated;
    end

    // The position counter and the overflow mark restart after the last request of a vector.
    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept)
        begin
            if (last_item)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                if (!saturated)
                begin
                    count_next = count_reg + tks_pkg::CNT_W'(1);
                end
                ovf_next = ovf_reg || saturated;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[hdl/tks_fifo.sv]
`timescale 1ns / 1ps

module tks_fifo
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  tks_pkg::tks_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output tks_pkg::tks_item_t pop_item
);

    tks_pkg::tks_item_t                mem_reg [tks_pkg::QUEUE_DEPTH];
    logic [tks_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [tks_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [tks_pkg::QUEUE_PTR_W:0]     fill_reg;
    logic                              push;
    logic                              pop;

    assign push_ready = (fill_reg != (tks_pkg::QUEUE_PTR_W + 1)'(tks_pkg::QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    function automatic logic [tks_pkg::QUEUE_PTR_W-1:0] ptr_inc(
        input logic [tks_pkg::QUEUE_PTR_W-1:0] p
    );
        if (p == tks_pkg::QUEUE_PTR_W'(tks_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + tks_pkg::QUEUE_PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (tks_pkg::QUEUE_PTR_W + 1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (tks_pkg::QUEUE_PTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hdl/tks_back.sv]
`timescale 1ns / 1ps

module tks_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    output logic                                 q_ready,
    input  tks_pkg::tks_item_t                   q_item,
    input  logic signed [tks_pkg::SCALE_W-1:0]   scale,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [tks_pkg::SCORE_W-1:0]   score_value,
    output logic [tks_pkg::CLASS_W-1:0]          class_index,
    output logic                                 rank_last,
    output logic                                 overflow
);

    // Multiply stage.
    logic                                 a_valid_reg;
    logic signed [tks_pkg::SCORE_W-1:0]   a_score_reg;
    logic [tks_pkg::CLASS_W-1:0]          a_idx_reg;
    logic                                 a_last_reg;
    logic                                 a_ovf_reg;
    logic signed [tks_pkg::PROD_W-1:0]    prod;

    // Working ranking and the ranking being drained to the output.
    tks_pkg::tks_slot_t                   slot_reg [tks_pkg::TOP_K];
    logic [tks_pkg::TOP_K-1:0]            valid_reg;
    tks_pkg::tks_slot_t                   emit_reg [tks_pkg::TOP_K];
    logic [tks_pkg::SLOT_CNT_W-1:0]       emit_rem_reg;
    logic                                 emit_ovf_reg;

    tks_pkg::tks_slot_t                   new_slot;
    tks_pkg::tks_slot_t                   ins_slot [tks_pkg::TOP_K];
    logic [tks_pkg::TOP_K-1:0]            ins_valid;
    logic [tks_pkg::TOP_K-1:0]            ge;
    logic [tks_pkg::SLOT_CNT_W-1:0]       ins_count;

    logic                                 out_fire;
    logic                                 emit_free;
    logic                                 b_take;
    logic                                 a_take;

    assign prod = q_item.diff * scale;

    assign out_valid   = (emit_rem_reg != '0);
    assign out_fire    = out_valid && out_ready;
    assign emit_free   = !out_valid
                      || (out_fire && emit_rem_reg == tks_pkg::SLOT_CNT_W'(1));
    assign b_take      = a_valid_reg && (!a_last_reg || emit_free);
    assign a_take      = !a_valid_reg || b_take;
    assign q_ready     = a_take;

    assign score_value = emit_reg[0].score;
    assign class_index = emit_reg[0].class_idx;
    assign rank_last   = (emit_rem_reg == tks_pkg::SLOT_CNT_W'(1));
    assign overflow    = emit_ovf_reg;

    // The slots are kept in descending order, so the slots that stay ahead of the new
    // score form a prefix. An equal score already held stays ahead of the newcomer.
    always_comb
    begin
        new_slot.score     = a_score_reg;
        new_slot.class_idx = a_idx_reg;
        for (int i = 0; i < tks_pkg::TOP_K; i++)
        begin
            ge[i] = valid_reg[i] && ($signed(slot_reg[i].score) >= $signed(a_score_reg));
        end
        ins_slot[0]  = ge[0] ? slot_reg[0] : new_slot;
        ins_valid[0] = 1'b1;
        for (int i = 1; i < tks_pkg::TOP_K; i++)
        begin
            if (ge[i])
            begin
                ins_slot[i] = slot_reg[i];
            end
            else if (ge[i-1])
            begin
                ins_slot[i] = new_slot;
            end
            else
            begin
                ins_slot[i] = slot_reg[i-1];
            end
            ins_valid[i] = valid_reg[i] || valid_reg[i-1];
        end
        ins_count = '0;
        for (int i = 0; i < tks_pkg::TOP_K; i++)
        begin
            ins_count = ins_count + tks_pkg::SLOT_CNT_W'(ins_valid[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            valid_reg    <= '0;
            emit_rem_reg <= '0;
        end
        else
        begin
            if (a_take)
            begin
                a_valid_reg <= q_valid;
            end
            if (b_take)
            begin
                valid_reg <= a_last_reg ? '0 : ins_valid;
            end
            if (b_take && a_last_reg)
            begin
                emit_rem_reg <= ins_count;
            end
            else if (out_fire)
            begin
                emit_rem_reg <= emit_rem_reg - tks_pkg::SLOT_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_take && q_valid)
        begin
            a_score_reg <= prod[tks_pkg::SCORE_W-1:0];
            a_idx_reg   <= q_item.class_idx;
            a_last_reg  <= q_item.last;
            a_ovf_reg   <= q_item.ovf;
        end
        if (b_take && !a_last_reg)
        begin
            for (int i = 0; i < tks_pkg::TOP_K; i++)
            begin
                slot_reg[i] <= ins_slot[i];
            end
        end
        if (b_take && a_last_reg)
        begin
            for (int i = 0; i < tks_pkg::TOP_K; i++)
            begin
                emit_reg[i] <= ins_slot[i];
            end
            emit_ovf_reg <= a_ovf_reg;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < tks_pkg::TOP_K - 1; i++)
            begin
                emit_reg[i] <= emit_reg[i+1];
            end
        end
    end

endmodule

[hdl/top_k_select_int8_dequant.sv]
`timescale 1ns / 1ps

// Channel   Signals                                                  Request
// in        in_valid / in_ready                                      score_code, last_item
// out       out_valid / out_ready                                    score_value, class_index,
//                                                                    rank_last, overflow
// cfg       cfg_wr_en, cfg_index, cfg_data                           zero_point (0), scale (1)
//
// One input request per cycle. A score passes the front, a four-entry queue, the multiply
// register and the slot insert. A last request loads the ranking into the output registers,
// which offer one result per cycle while out_ready is high, min(count, TOP_K) results in all.
// The next vector is inserted meanwhile; only a further last request waits while a ranking
// is still draining, and the input stalls once the queue behind it is full.
// Reset empties the slots and counters, and sets zero_point to 0 and scale to 1.0.

module top_k_select_int8_dequant
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [tks_pkg::CODE_W-1:0]     score_code,
    input  logic                                  last_item,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tks_pkg::SCORE_W-1:0]    score_value,
    output logic [tks_pkg::CLASS_W-1:0]           class_index,
    output logic                                  rank_last,
    output logic                                  overflow,
    input  logic                                  cfg_wr_en,
    input  logic [tks_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tks_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic signed [tks_pkg::ZP_W-1:0]    zero_point_reg;
    logic signed [tks_pkg::SCALE_W-1:0] scale_reg;

    logic               fq_valid;
    logic               fq_ready;
    tks_pkg::tks_item_t fq_item;
    logic               qb_valid;
    logic               qb_ready;
    tks_pkg::tks_item_t qb_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_point_reg <= tks_pkg::ZERO_POINT_RESET;
            scale_reg      <= tks_pkg::SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                tks_pkg::REG_ZERO_POINT: zero_point_reg <= cfg_data[tks_pkg::ZP_W-1:0];
                tks_pkg::REG_SCALE:      scale_reg      <= cfg_data[tks_pkg::SCALE_W-1:0];
                default:                 ;
            endcase
        end
    end

    tks_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .score_code (score_code),
        .last_item  (last_item),
        .zero_point (zero_point_reg),
        .q_valid    (fq_valid),
        .q_ready    (fq_ready),
        .q_item     (fq_item)
    );

    tks_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    tks_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (qb_valid),
        .q_ready     (qb_ready),
        .q_item      (qb_item),
        .scale       (scale_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .score_value (score_value),
        .class_index (class_index),
        .rank_last   (rank_last),
        .overflow    (overflow)
    );

endmodule

[hdl/tks_checker.sv]
`timescale 1ns / 1ps

module tks_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic signed [tks_pkg::CODE_W-1:0]   score_code,
    input logic                                last_item,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [tks_pkg::SCORE_W-1:0]  score_value,
    input logic [tks_pkg::CLASS_W-1:0]         class_index,
    input logic                                rank_last,
    input logic                                overflow
);

    // A stalled input request keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(score_code) && $stable(last_item))
        else $error("input request changed while stalled");

    // A stalled result request keeps its valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped while stalled");

    // A stalled result request keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(score_value) && $stable(class_index)
                                    && $stable(rank_last) && $stable(overflow))
        else $error("result payload changed while stalled");

    // A ranking is delivered without gaps and with one overflow flag throughout.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !rank_last |=> out_valid && overflow == $past(overflow))
        else $error("ranking interrupted or overflow flag changed");

    // Entries of one ranking come best first; equal scores in rising class order.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !rank_last |=>
            ($signed(score_value) < $signed($past(score_value)))
            || (score_value == $past(score_value) && class_index >= $past(class_index)))
        else $error("ranking out of order");

endmodule

bind top_k_select_int8_dequant tks_checker u_tks_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .score_code  (score_code),
    .last_item   (last_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .score_value (score_value),
    .class_index (class_index),
    .rank_last   (rank_last),
    .overflow    (overflow)
);
